// ===== rtl/core/tsee_pkg.sv =====
// ----------------------------------------------------------------------------
// tsee_pkg: shared constants and helpers for the terrain skirt edge emitter
// Register indexes, default widths, and the skirt strip vertex order.
// ----------------------------------------------------------------------------
`default_nettype none

package tsee_pkg;

  // default field widths
  localparam int unsigned COORD_WIDTH  = 32;
  localparam int unsigned NORMAL_WIDTH = 16;
  localparam int unsigned COLOR_W      = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned UCFG_W     = 31;  // size, eps, depth registers

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X  = 3'd0,
    CFG_MIN_Z  = 3'd1,
    CFG_SIZE   = 3'd2,
    CFG_EPS    = 3'd3,
    CFG_DEPTH  = 3'd4,
    CFG_COLORS = 3'd5
  } cfg_reg_e;

  localparam logic [COLOR_W-1:0] WHITE_RGBA = {COLOR_W{1'b1}};

  // triangle queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // vertex position within a triangle
  localparam int unsigned    PHASE_W     = 2;
  localparam logic [PHASE_W-1:0] PHASE_THIRD = 2'd2;

  // skirt strip: 12 vertices per edge, front quad then reversed copy
  localparam int unsigned        STEP_W    = 4;
  localparam logic [STEP_W-1:0]  LAST_STEP = 4'd11;
  localparam int unsigned        EDGE_CNT  = 3;

  // fold the back-face half onto the front-face half
  function automatic logic [STEP_W-1:0] strip_slot(input logic [STEP_W-1:0] step);
    return (step < 4'd6) ? step : STEP_W'(LAST_STEP - step);
  endfunction

  // 1: endpoint b, 0: endpoint a
  function automatic logic skirt_end(input logic [STEP_W-1:0] step);
    logic [STEP_W-1:0] s;
    s = strip_slot(step);
    return s inside {4'd2, 4'd3, 4'd5};
  endfunction

  // 1: dropped vertex
  function automatic logic skirt_down(input logic [STEP_W-1:0] step);
    logic [STEP_W-1:0] s;
    s = strip_slot(step);
    return s inside {4'd1, 4'd4, 4'd5};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/terrain_skirt_edge_emitter_unit.sv =====
// ----------------------------------------------------------------------------
// terrain_skirt_edge_emitter_unit: terrain chunk skirt generator
// Builds downward skirt strips along triangle edges that lie on a chunk side.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries a triangle-list vertex stream, three requests per triangle.
//    One vertex request is taken per cycle while the triangle queue has room.
//  - On the third vertex each edge (0-1, 1-2, 2-0) is checked against the four
//    chunk side planes; a qualifying edge produces 12 m_axis requests (front
//    quad, then the same six reversed). tlast marks the last of a triangle.
//  - The third vertex is written into the triangle queue, then popped into
//    the sequencer, which registers the first skirt vertex in its output
//    stage. The back end emits one vertex per cycle unless the output stalls.
//  - Throughput is set by the output sequencer; a two-entry triangle queue
//    absorbs bursts, and intake stalls only on a third vertex when it is full.
//  - A stalled receiver freezes the output register; the queue and intake keep
//    running until the queue fills.
//  - Reset clears the vertex phase, queue and config registers (all skirts disabled
//    because skirt_depth resets to zero). Write config only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module terrain_skirt_edge_emitter_unit import tsee_pkg::*; #(
  parameter int unsigned CW = COORD_WIDTH,
  parameter int unsigned NW = NORMAL_WIDTH,
  localparam int unsigned VTX_W = 3*CW + 3*NW + COLOR_W,
  localparam int unsigned TW    = ((VTX_W + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // vertex input
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, vertex_color
  input  wire logic [TW-1:0]         s_axis_tdata,
  // skirt vertex output
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_x, out_y, out_z, out_nx, out_ny, out_nz, out_color
  output logic [TW-1:0]              m_axis_tdata,
  output logic                       m_axis_tlast   // last_of_run
);

  localparam int unsigned REC_W = 3*VTX_W + EDGE_CNT;
  localparam int unsigned CNTW  = $clog2(QUEUE_DEPTH+1);

  // configuration registers
  logic [CFG_DATA_W-1:0] chunk_min_x_q, chunk_min_z_q;
  logic [UCFG_W-1:0]     chunk_size_q, border_eps_q, skirt_depth_q;
  logic                  colors_present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_min_x_q    <= '0;
      chunk_min_z_q    <= '0;
      chunk_size_q     <= '0;
      border_eps_q     <= '0;
      skirt_depth_q    <= '0;
      colors_present_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MIN_X:  chunk_min_x_q    <= cfg_data_i;
        CFG_MIN_Z:  chunk_min_z_q    <= cfg_data_i;
        CFG_SIZE:   chunk_size_q     <= cfg_data_i[UCFG_W-1:0];
        CFG_EPS:    border_eps_q     <= cfg_data_i[UCFG_W-1:0];
        CFG_DEPTH:  skirt_depth_q    <= cfg_data_i[UCFG_W-1:0];
        CFG_COLORS: colors_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // front -> queue -> back
  logic             q_push, q_pop, q_full, q_empty;
  logic [REC_W-1:0] q_wdata, q_rdata;
  logic [CNTW-1:0]  q_count;

  tsee_front #(
    .CW(CW), .NW(NW), .TW(TW), .REC_W(REC_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_o    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .chunk_min_x_i (chunk_min_x_q),
    .chunk_min_z_i (chunk_min_z_q),
    .chunk_size_i  (chunk_size_q),
    .border_eps_i  (border_eps_q),
    .skirt_depth_i (skirt_depth_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  tsee_queue #(
    .WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  tsee_back #(
    .CW(CW), .NW(NW), .TW(TW), .REC_W(REC_W)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (!q_empty),
    .q_data_i         (q_rdata),
    .q_pop_o          (q_pop),
    .skirt_depth_i    (skirt_depth_q),
    .colors_present_i (colors_present_q),
    .m_tvalid_o       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_o        (m_axis_tdata),
    .m_tlast_o        (m_axis_tlast)
  );

  // disabled skirts never queue a triangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skirt_depth_q == '0) |-> !q_push)
    else $error("triangle queued with zero skirt depth");

  // back end only takes a triangle that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_count != '0))
    else $error("pop from empty triangle queue");

  // intake must stall rather than overrun the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_count != CNTW'(QUEUE_DEPTH)))
    else $error("push into full triangle queue");

endmodule

`default_nettype wire

// ===== rtl/core/tsee_front.sv =====
// ----------------------------------------------------------------------------
// tsee_front: vertex intake and border classification
// Holds a triangle's first two vertices and plane flags; on the third vertex
// it builds the qualifying edge mask and queues the triangle if it has skirts.
// ----------------------------------------------------------------------------
`default_nettype none

module tsee_front import tsee_pkg::*; #(
  parameter int unsigned CW    = COORD_WIDTH,
  parameter int unsigned NW    = NORMAL_WIDTH,
  parameter int unsigned TW    = 176,
  parameter int unsigned REC_W = 531
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  output logic                        s_tready_o,
  input  wire logic [TW-1:0]          s_tdata_i,
  input  wire logic [CFG_DATA_W-1:0]  chunk_min_x_i,
  input  wire logic [CFG_DATA_W-1:0]  chunk_min_z_i,
  input  wire logic [UCFG_W-1:0]      chunk_size_i,
  input  wire logic [UCFG_W-1:0]      border_eps_i,
  input  wire logic [UCFG_W-1:0]      skirt_depth_i,
  input  wire logic                   q_full_i,
  output logic                        q_push_o,
  output logic [REC_W-1:0]            q_data_o
);

  // last field (px) lands in the lowest bits
  typedef struct packed {
    logic [COLOR_W-1:0] rgba;
    logic [NW-1:0]      nz;
    logic [NW-1:0]      ny;
    logic [NW-1:0]      nx;
    logic [CW-1:0]      pz;
    logic [CW-1:0]      py;
    logic [CW-1:0]      px;
  } vtx_t;

  typedef struct packed {
    vtx_t [2:0]            v;
    logic [EDGE_CNT-1:0]   mask;
  } tri_t;

  localparam int unsigned VTX_W = $bits(vtx_t);
  localparam int unsigned DW    = ((CW > 32) ? CW : 32) + 3;

  vtx_t in_vtx;
  tri_t rec;

  logic [PHASE_W-1:0] phase_q, phase_d;
  vtx_t               held_v_q [2];
  logic [3:0]         held_f_q [2];

  logic signed [DW-1:0] dx, ex, dz, ez, eps_s, neg_eps;
  logic [3:0]           in_f;
  logic                 accept, third;
  logic [EDGE_CNT-1:0]  mask;

  assign in_vtx = vtx_t'(s_tdata_i[VTX_W-1:0]);

  // exact signed distances to the four side planes
  assign dx      = DW'($signed(in_vtx.px)) - DW'($signed(chunk_min_x_i));
  assign dz      = DW'($signed(in_vtx.pz)) - DW'($signed(chunk_min_z_i));
  assign ex      = dx - $signed(DW'(chunk_size_i));
  assign ez      = dz - $signed(DW'(chunk_size_i));
  assign eps_s   = $signed(DW'(border_eps_i));
  assign neg_eps = -eps_s;

  // flags: {z max, z min, x max, x min}
  assign in_f = {(ez < eps_s) && (ez > neg_eps), (dz < eps_s) && (dz > neg_eps),
                 (ex < eps_s) && (ex > neg_eps), (dx < eps_s) && (dx > neg_eps)};

  // edges 0-1, 1-2, 2-0
  assign mask = {|(in_f & held_f_q[0]), |(held_f_q[1] & in_f),
                 |(held_f_q[0] & held_f_q[1])};

  assign s_tready_o = (phase_q != PHASE_THIRD) || !q_full_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign third      = (phase_q == PHASE_THIRD);

  assign q_push_o = accept && third && (skirt_depth_i != '0) && (mask != '0);

  always_comb begin
    rec.v[2] = in_vtx;
    rec.v[1] = held_v_q[1];
    rec.v[0] = held_v_q[0];
    rec.mask = mask;
  end
  assign q_data_o = REC_W'(rec);

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = third ? '0 : PHASE_W'(phase_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !third) begin
      held_v_q[phase_q[0]] <= in_vtx;
      held_f_q[phase_q[0]] <= in_f;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsee_queue.sv =====
// ----------------------------------------------------------------------------
// tsee_queue: small flop queue of classified triangles
// Decouples intake from skirt emission; first-word-through head output.
// ----------------------------------------------------------------------------
`default_nettype none

module tsee_queue import tsee_pkg::*; #(
  parameter int unsigned WIDTH = 531,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [WIDTH-1:0]             data_i,
  input  wire logic                         pop_i,
  output logic [WIDTH-1:0]                  data_o,
  output logic                              full_o,
  output logic                              empty_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : PW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : PW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= CNTW'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= CNTW'(count_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsee_back.sv =====
// ----------------------------------------------------------------------------
// tsee_back: skirt strip sequencer
// Walks the qualifying edges of the head triangle, 12 vertices per edge,
// one per cycle into a registered output stage unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tsee_back import tsee_pkg::*; #(
  parameter int unsigned CW    = COORD_WIDTH,
  parameter int unsigned NW    = NORMAL_WIDTH,
  parameter int unsigned TW    = 176,
  parameter int unsigned REC_W = 531
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire logic [REC_W-1:0]   q_data_i,
  output logic                    q_pop_o,
  input  wire logic [UCFG_W-1:0]  skirt_depth_i,
  input  wire logic               colors_present_i,
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  output logic [TW-1:0]           m_tdata_o,
  output logic                    m_tlast_o
);

  typedef struct packed {
    logic [COLOR_W-1:0] rgba;
    logic [NW-1:0]      nz;
    logic [NW-1:0]      ny;
    logic [NW-1:0]      nx;
    logic [CW-1:0]      pz;
    logic [CW-1:0]      py;
    logic [CW-1:0]      px;
  } vtx_t;

  typedef struct packed {
    vtx_t [2:0]            v;
    logic [EDGE_CNT-1:0]   mask;
  } tri_t;

  tri_t                rec;
  vtx_t [2:0]          v_q;
  logic [EDGE_CNT-1:0] mask_q, mask_d, cur_bit, rest;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [1:0]          ia, ib;
  vtx_t                sel, o_vtx, out_q;
  logic                out_valid_q, out_last_q;
  logic                adv, produce, edge_done, last_vtx;

  assign rec = tri_t'(q_data_i);

  // lowest pending edge
  always_comb begin
    if (mask_q[0]) begin
      ia = 2'd0; ib = 2'd1; cur_bit = 3'b001;
    end else if (mask_q[1]) begin
      ia = 2'd1; ib = 2'd2; cur_bit = 3'b010;
    end else begin
      ia = 2'd2; ib = 2'd0; cur_bit = 3'b100;
    end
  end

  assign rest      = mask_q & ~cur_bit;
  assign adv       = !out_valid_q || m_tready_i;
  assign produce   = (mask_q != '0) && adv;
  assign edge_done = produce && (step_q == LAST_STEP);
  assign last_vtx  = (step_q == LAST_STEP) && (rest == '0);
  assign q_pop_o   = q_valid_i && ((mask_q == '0) || (edge_done && rest == '0));

  always_comb begin
    sel   = skirt_end(step_q) ? v_q[ib] : v_q[ia];
    o_vtx = sel;
    if (skirt_down(step_q)) begin
      o_vtx.py = sel.py - CW'(skirt_depth_i);
    end
    if (!colors_present_i) begin
      o_vtx.rgba = WHITE_RGBA;
    end
  end

  always_comb begin
    mask_d = mask_q;
    step_d = step_q;
    if (produce) begin
      step_d = (step_q == LAST_STEP) ? '0 : STEP_W'(step_q + 1'b1);
    end
    if (edge_done) begin
      mask_d = rest;
    end
    if (q_pop_o) begin
      mask_d = rec.mask;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      step_q <= step_d;
      if (adv) begin
        out_valid_q <= produce;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      v_q <= rec.v;
    end
    if (produce) begin
      out_q      <= o_vtx;
      out_last_q <= last_vtx;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = TW'(out_q);
  assign m_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for terrain_skirt_edge_emitter_unit
// Streams triangle-list vertices into the emitter and keeps its own mirror of
// the triangle assembly and chunk border test. Every skirt vertex that comes
// out is checked field by field against the expected strip. The run covers
// directed border cases, then random triangles under changing chunk setups
// and changing stall patterns on both sides.
// ----------------------------------------------------------------------------

module tb_top;
  import tsee_pkg::*;

  localparam int unsigned TW = ((3*COORD_WIDTH + 3*NORMAL_WIDTH + COLOR_W + 7) / 8) * 8;

  // cycles allowed after the last expected vertex
  localparam int unsigned SETTLE_CYCLES   = 16;
  // long receiver hold-off, sized so the two-entry triangle queue fills up
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_PRINTS      = 40;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  // index with no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  // skirt strip slots 0..5: a, a down, b, b, a down, b down
  localparam logic [5:0] SLOT_USES_B  = 6'b101100;
  localparam logic [5:0] SLOT_DROPPED = 6'b110010;

  // directed chunk: x in [10, 26], z in [-5, 11], Q16.16
  localparam logic [31:0] D_MIN_X = 32'h000A_0000;
  localparam logic [31:0] D_MIN_Z = 32'hFFFB_0000;
  localparam logic [31:0] D_SIZE  = 32'h0010_0000;
  localparam logic [31:0] D_MAX_X = 32'h001A_0000;
  localparam logic [31:0] D_MAX_Z = 32'h000B_0000;
  localparam logic [31:0] D_MID_X = 32'h0012_0000;
  localparam logic [31:0] D_MID_Z = 32'h0003_0000;
  localparam logic [31:0] D_EPS   = 32'd2097;       // size * 0.002
  localparam logic [31:0] D_DEPTH = 32'h0002_0000;

  // Field order is reversed here so that the packed value matches the bus
  // layout: pos_x sits in the lowest bits, vertex_color in the highest.
  typedef struct packed {
    logic [31:0]        rgba;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vertex_t;

  typedef struct {
    vertex_t v;
    logic    last;
  } skirt_t;

  // --------------------------------------------------------------------------
  // clock, reset, DUT ports
  // --------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, vertex_color
  logic [TW-1:0]         s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // out_x, out_y, out_z, out_nx, out_ny, out_nz, out_color
  logic [TW-1:0]         m_axis_tdata;
  logic                  m_axis_tlast;  // last_of_run

  always #2 clk_i = ~clk_i;

  terrain_skirt_edge_emitter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  vertex_t vertex_q[$];     // vertex requests waiting to be offered
  skirt_t  skirt_q[$];      // skirt vertices expected, oldest first
  vertex_t offered_vertex;  // request currently on s_axis

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_off_go  = 1'b0;
  logic        recv_frozen  = 1'b0;
  int unsigned n_mismatch   = 0;
  int unsigned n_skirts     = 0;

  // mirror of the chunk setup registers
  logic signed [31:0] min_x_r  = '0;
  logic signed [31:0] min_z_r  = '0;
  logic [30:0]        size_r   = '0;
  logic [30:0]        eps_r    = '0;
  logic [30:0]        depth_r  = '0;
  logic               colors_r = 1'b0;

  // triangle assembly mirror
  vertex_t     held_vtx[2];
  int unsigned corner_cnt = 0;

  // --------------------------------------------------------------------------
  // expected behavior
  // --------------------------------------------------------------------------

  // |p - (base + off)| < eps, in 64 bits so nothing can wrap
  function automatic bit near_side(logic signed [31:0] p, logic signed [31:0] base,
                                   logic [30:0] off);
    longint gap;
    gap = longint'(p) - longint'(base) - longint'(off);
    if (gap < 0) gap = -gap;
    return gap < longint'(eps_r);
  endfunction

  function automatic bit share_side(vertex_t a, vertex_t b);
    return (near_side(a.x, min_x_r, '0)    && near_side(b.x, min_x_r, '0))    ||
           (near_side(a.x, min_x_r, size_r) && near_side(b.x, min_x_r, size_r)) ||
           (near_side(a.z, min_z_r, '0)    && near_side(b.z, min_z_r, '0))    ||
           (near_side(a.z, min_z_r, size_r) && near_side(b.z, min_z_r, size_r));
  endfunction

  // 12 strip vertices for edge a-b: front quad, then the same six reversed
  function automatic void emit_edge(vertex_t a, vertex_t b);
    skirt_t  s;
    vertex_t src;
    int      slot;
    for (int i = 0; i < 12; i++) begin
      slot = (i < 6) ? i : 11 - i;
      src  = SLOT_USES_B[slot] ? b : a;
      s.v  = src;
      if (SLOT_DROPPED[slot]) s.v.y = src.y - {1'b0, depth_r};
      if (!colors_r) s.v.rgba = WHITE_RGBA;
      s.last = 1'b0;
      skirt_q.insert(skirt_q.size(), s);
    end
  endfunction

  // one accepted vertex request: hold the first two, build skirts on the third
  function automatic void take_vertex(vertex_t v);
    vertex_t corner[3];
    int      before_cnt;
    if (corner_cnt < 2) begin
      held_vtx[corner_cnt] = v;
      corner_cnt++;
      return;
    end
    corner_cnt = 0;
    if (depth_r == '0) return;   // skirts disabled, triangle dropped
    corner[0] = held_vtx[0];
    corner[1] = held_vtx[1];
    corner[2] = v;
    before_cnt = skirt_q.size();
    for (int e = 0; e < 3; e++)
      if (share_side(corner[e], corner[(e + 1) % 3]))
        emit_edge(corner[e], corner[(e + 1) % 3]);
    if (skirt_q.size() > before_cnt) skirt_q[$].last = 1'b1;
  endfunction

  // append one vertex request to the stimulus queue
  function automatic void add_vertex(vertex_t v);
    vertex_q.insert(vertex_q.size(), v);
  endfunction

  // --------------------------------------------------------------------------
  // driver: offers queued vertex requests, holds each until taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_vertex(offered_vertex);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (vertex_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered_vertex = vertex_q[0];
          vertex_q.delete(0);
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= offered_vertex;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random ready, checks each skirt vertex taken
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    n_mismatch++;
    if (n_mismatch <= MAX_PRINTS)
      $display("%0t ns: skirt vertex %0d %s: expected %h, got %h",
               $time, n_skirts, what, want, got);
  endtask

  task automatic check_skirt(vertex_t got, logic got_last);
    skirt_t want;
    if (skirt_q.size() == 0) begin
      report_mismatch("arrived with nothing expected", '0, got.x);
    end else begin
      want = skirt_q[0];
      skirt_q.delete(0);
      if (got.x    !== want.v.x)    report_mismatch("out_x", want.v.x, got.x);
      if (got.y    !== want.v.y)    report_mismatch("out_y", want.v.y, got.y);
      if (got.z    !== want.v.z)    report_mismatch("out_z", want.v.z, got.z);
      if (got.nx   !== want.v.nx)
        report_mismatch("out_nx", 32'(want.v.nx), 32'(got.nx));
      if (got.ny   !== want.v.ny)
        report_mismatch("out_ny", 32'(want.v.ny), 32'(got.ny));
      if (got.nz   !== want.v.nz)
        report_mismatch("out_nz", 32'(want.v.nz), 32'(got.nz));
      if (got.rgba !== want.v.rgba) report_mismatch("out_color", want.v.rgba, got.rgba);
      if (got_last !== want.last)
        report_mismatch("last_of_run", 32'(want.last), 32'(got_last));
    end
    n_skirts++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_skirt(vertex_t'(m_axis_tdata), m_axis_tlast);
      m_axis_tready <= !recv_frozen && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, counted here; the sender keeps going meanwhile
  always begin
    @(posedge hold_off_go);
    @(posedge clk_i);
    recv_frozen <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    recv_frozen <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // write one register, dropping the enable before returning so back-to-back writes never collide
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MIN_X:  min_x_r  = val;
      CFG_MIN_Z:  min_z_r  = val;
      CFG_SIZE:   size_r   = val[30:0];
      CFG_EPS:    eps_r    = val[30:0];
      CFG_DEPTH:  depth_r  = val[30:0];
      CFG_COLORS: colors_r = val[0];
      default: ;
    endcase
  endtask

  task automatic write_setup(logic [31:0] mx, logic [31:0] mz, logic [31:0] sz,
                             logic [31:0] ep, logic [31:0] dp, logic [31:0] col);
    write_reg(CFG_MIN_X, mx);
    write_reg(CFG_MIN_Z, mz);
    write_reg(CFG_SIZE, sz);
    write_reg(CFG_EPS, ep);
    write_reg(CFG_DEPTH, dp);
    write_reg(CFG_COLORS, col);
    @(negedge clk_i);
  endtask

  // sender pause: every request taken, every skirt vertex seen, pipe settled
  task automatic drain();
    do @(negedge clk_i);
    while (vertex_q.size() != 0 || s_axis_tvalid || skirt_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.x    = $urandom;
    v.y    = $urandom;
    v.z    = $urandom;
    v.nx   = 16'($urandom);
    v.ny   = 16'($urandom);
    v.nz   = 16'($urandom);
    v.rgba = $urandom;
    return v;
  endfunction

  function automatic vertex_t at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vertex_t v;
    v   = rand_vertex();
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  // coordinate within tolerance of a plane; now and then exactly on the limit
  function automatic logic [31:0] near_coord(longint plane);
    longint d;
    longint c;
    if (eps_r == '0)                      d = 0;
    else if ($urandom_range(0, 15) == 0) d = longint'(eps_r);
    else                                  d = longint'($urandom_range(0, eps_r - 1));
    c = $urandom_range(0, 1) ? plane + d : plane - d;
    if (c > COORD_MAX) c = plane - d;
    if (c < COORD_MIN) c = plane + d;
    if (c > COORD_MAX) c = COORD_MAX;   // far side out of range altogether
    return c[31:0];
  endfunction

  // side: 0 x min, 1 x max, 2 z min, 3 z max
  function automatic vertex_t side_vertex(int side);
    vertex_t v;
    longint  base;
    v    = rand_vertex();
    base = (side < 2) ? longint'(min_x_r) : longint'(min_z_r);
    if (side % 2 == 1) base += longint'(size_r);
    if (side < 2) v.x = near_coord(base);
    else          v.z = near_coord(base);
    return v;
  endfunction

  // mostly triangles that touch one chunk side; sometimes pure noise
  function automatic void push_triangle(bit on_border);
    vertex_t v;
    int      side;
    bit      noise;
    side  = $urandom_range(0, 3);
    noise = !on_border && $urandom_range(0, 4) == 0;
    for (int k = 0; k < 3; k++) begin
      if (noise || (!(on_border && k < 2) && $urandom_range(0, 3) == 0)) begin
        v = rand_vertex();
      end else begin
        v = side_vertex(side);
        if ($urandom_range(0, 7) == 0) begin
          // corner vertex, also close to a perpendicular side
          if (side < 2) v.z = side_vertex(2 + $urandom_range(0, 1)).z;
          else          v.x = side_vertex($urandom_range(0, 1)).x;
        end
      end
      add_vertex(v);
    end
  endfunction

  task automatic random_setup();
    logic [31:0] sz;
    logic [31:0] ep;
    logic [31:0] dp;
    logic [2:0]  top;
    top = 3'($urandom);
    sz  = $urandom_range(32'h0001_0000, 32'h1000_0000);
    if ($urandom_range(0, 5) == 0) sz = 32'h7FFF_FFFF;
    ep = sz / 500 + 1;
    if ($urandom_range(0, 5) == 0) ep = $urandom;   // wide tolerance, many edges
    if (ep[30:0] == '0) ep = 32'd1;
    dp = $urandom_range(1, 32'h7FFF_FFFF);
    // bit 31 of the data for the 31-bit registers is random and must be ignored
    write_setup($urandom, $urandom, {top[0], sz[30:0]}, {top[1], ep[30:0]},
                {top[2], dp[30:0]}, $urandom);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    vertex_t     v;
    int unsigned send_pct_by_mode[3];
    int unsigned recv_pct_by_mode[3];
    send_pct_by_mode = '{36, 88, 0};
    recv_pct_by_mode = '{88, 36, 0};

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_MIN_X;
    cfg_data_i    = '0;
    send_idle_pct = send_pct_by_mode[0];
    recv_idle_pct = recv_pct_by_mode[0];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed: small chunk, colors on --------------------------------
    write_reg(CFG_SPARE_IDX, $urandom);
    write_setup(D_MIN_X, D_MIN_Z, D_SIZE, D_EPS, D_DEPTH, 32'd1);

    // all vertices on x min: every edge qualifies, extreme normals and colors, and a
    // dropped y that wraps below the most negative coordinate
    v      = at(D_MIN_X, 32'h8000_0000, D_MID_Z);
    v.nx   = 16'sh8000;
    v.ny   = 16'sh7FFF;
    v.nz   = '0;
    v.rgba = 32'h0000_0000;
    add_vertex(v);
    v      = at(D_MIN_X + 100, 32'h7FFF_FFFF, D_MIN_Z);
    v.nx   = 16'sh7FFF;
    v.ny   = 16'sh8000;
    v.nz   = 16'shFFFF;
    v.rgba = 32'hFFFF_FFFF;
    add_vertex(v);
    add_vertex(at(D_MIN_X - (D_EPS - 1), 32'h0000_0000, D_MAX_Z));
    // far corner: edge 0-1 on z max, edge 2-0 on x max, 1-2 not on a side
    add_vertex(at(D_MAX_X, $urandom, D_MAX_Z));
    add_vertex(at(D_MID_X, $urandom, D_MAX_Z + 5));
    add_vertex(at(D_MAX_X - 3, $urandom, D_MID_Z));
    // edge on two sides at once still gives one strip
    add_vertex(at(D_MIN_X, $urandom, D_MIN_Z));
    add_vertex(at(D_MIN_X + 1, $urandom, D_MIN_Z - 1));
    add_vertex(at(D_MID_X, $urandom, D_MID_Z));
    // exactly one tolerance away on each side: not on the border
    add_vertex(at(D_MIN_X + D_EPS, $urandom, D_MID_Z));
    add_vertex(at(D_MIN_X - D_EPS, $urandom, D_MID_Z));
    add_vertex(at(D_MID_X, $urandom, D_MID_Z));
    drain();

    // ---- directed: extreme chunk, colors off, full depth -----------------
    // x max plane is -1, z max plane lies beyond the coordinate range
    write_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                32'hFFFF_FFFF, 32'hFFFF_FFFE);
    add_vertex(at(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000));
    add_vertex(at(32'h8000_0000, 32'h0000_0000, $urandom));
    add_vertex(at(32'h0000_0000, $urandom, 32'h0000_0000));
    add_vertex(at(32'hFFFF_FFFF, $urandom, 32'h7FFF_FFFF));
    add_vertex(at(32'hFFFF_FFFF, $urandom, 32'h8000_0000));
    add_vertex(at(32'h7FFF_FFFF, $urandom, 32'h7FFF_FFFF));
    drain();

    // zero tolerance: even a vertex right on the plane does not count
    write_reg(CFG_EPS, 32'h8000_0000);
    @(negedge clk_i);
    add_vertex(at(32'h8000_0000, $urandom, $urandom));
    add_vertex(at(32'h8000_0000, $urandom, $urandom));
    add_vertex(at(32'h8000_0000, $urandom, $urandom));
    drain();

    // zero depth: skirts off, but the triangle is still consumed
    write_reg(CFG_EPS, 32'd1);
    write_reg(CFG_DEPTH, 32'h8000_0000);
    @(negedge clk_i);
    add_vertex(at(32'h8000_0000, $urandom, $urandom));
    add_vertex(at(32'h8000_0000, $urandom, $urandom));
    add_vertex(at(32'h8000_0000, $urandom, $urandom));
    drain();

    // ---- random: three stall patterns, two chunk setups each -------------
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = send_pct_by_mode[m];
      recv_idle_pct = recv_pct_by_mode[m];
      for (int c = 0; c < 2; c++) begin
        random_setup();
        repeat (6) push_triangle(1'b0);
        if (m == 2 && c == 0) begin
          // receiver stops while a burst of border triangles keeps coming
          hold_off_go = 1'b1;
          repeat (8) push_triangle(1'b1);
        end
        drain();
      end
    end

    if (n_mismatch == 0) begin
      $display("PASS terrain_skirt_edge_emitter_unit");
    end else begin
      $display("FAIL terrain_skirt_edge_emitter_unit");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAIL terrain_skirt_edge_emitter_unit");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tsee_pkg.sv
rtl/core/tsee_front.sv
rtl/core/tsee_queue.sv
rtl/core/tsee_back.sv
rtl/core/terrain_skirt_edge_emitter_unit.sv
tb/tb_top.sv
